>>> rtl/hst_pkg.sv
// Shared types and constants for the handle slot table.
// No dependencies; every other file imports this package.
`default_nettype none
package hst_pkg;

  localparam int unsigned HST_TABLE_SIZE       = 64;
  localparam int unsigned HST_FIRST_ALLOC_SLOT = 3;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned HANDLE_W  = 64;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // slots 0..2 hold the standard handles; their reset handle equals the index
  localparam int unsigned NUM_STD = 3;
  localparam int unsigned STD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLACE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STDIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STDOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STDERR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID = 2'd3;

  localparam logic [HANDLE_W-1:0] INVALID_RESET = '1;

  typedef struct packed {
    logic accept;   // latch input beat, issue handle read
    logic exec;     // commit state update, load result register
    logic cfg_we;   // register write
  } hst_cmd_t;

  typedef struct packed {
    logic out_free; // result register can take a beat this cycle
  } hst_sts_t;

endpackage
`default_nettype wire

>>> rtl/hst_if.sv
// Channel interfaces: command input, result output, register write.
// Depends on hst_pkg for field widths.
`default_nettype none
interface hst_in_if import hst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_W-1:0]   slot;
  logic [HANDLE_W-1:0] handle;
  modport source (output valid, cmd, slot, handle, input ready);
  modport sink   (input valid, cmd, slot, handle, output ready);
endinterface

interface hst_out_if import hst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [HANDLE_W-1:0] handle_out;
  logic                in_use_out;
  modport source (output valid, status, slot_out, handle_out, in_use_out, input ready);
  modport sink   (input valid, status, slot_out, handle_out, in_use_out, output ready);
endinterface

interface hst_cfg_if import hst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [HANDLE_W-1:0]  data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface
`default_nettype wire

>>> rtl/handle_slot_table.sv
// Handle slot table top level: one result beat per command beat.
// Sequence: the command beat and the handle read are registered on accept; the result
// register is loaded in the execute state, later while the previous result beat waits for ready.
// A new command is taken only after the previous one executes (handle memory read, then write).
// Reset: slots 0-2 in use holding 0,1,2; invalid handle all ones; no clearing pass.
// Depends on hst_pkg, hst_if, hst_ctrl, hst_dp.
`default_nettype none
module handle_slot_table import hst_pkg::*; #(
  parameter int unsigned TABLE_SIZE       = HST_TABLE_SIZE,
  parameter int unsigned FIRST_ALLOC_SLOT = HST_FIRST_ALLOC_SLOT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hst_in_if.sink     in_i,
  hst_out_if.source  out_o,
  hst_cfg_if.sink    cfg_i
);

  hst_cmd_t cmd;
  hst_sts_t sts;

  hst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hst_dp #(
    .TABLE_SIZE       (TABLE_SIZE),
    .FIRST_ALLOC_SLOT (FIRST_ALLOC_SLOT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (in_i.cmd),
    .in_slot_i    (in_i.slot),
    .in_handle_i  (in_i.handle),
    .cfg_idx_i    (cfg_i.idx),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_slot_o   (out_o.slot_out),
    .out_handle_o (out_o.handle_out),
    .out_in_use_o (out_o.in_use_out)
  );

endmodule
`default_nettype wire

>>> rtl/hst_ctrl.sv
// Controller FSM: sequences accept and execute for each command beat.
// Depends on hst_pkg.
`default_nettype none
module hst_ctrl import hst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  hst_sts_t sts_i,
  output hst_cmd_t cmd_o
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.accept  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.cfg_we  = (state_q == ST_IDLE) && cfg_valid_i;
  assign cmd_o.exec    = (state_q == ST_EXEC) && sts_i.out_free;

endmodule
`default_nettype wire

>>> rtl/hst_dp.sv
// Datapath: in-use bits, handle memory, free-slot encoder, result register.
// Depends on hst_pkg; driven by hst_ctrl commands.
`default_nettype none
module hst_dp import hst_pkg::*; #(
  parameter int unsigned TABLE_SIZE       = HST_TABLE_SIZE,
  parameter int unsigned FIRST_ALLOC_SLOT = HST_FIRST_ALLOC_SLOT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hst_cmd_t             cmd_i,
  output hst_sts_t             sts_o,
  input  logic [CMD_W-1:0]     in_cmd_i,
  input  logic [SLOT_W-1:0]    in_slot_i,
  input  logic [HANDLE_W-1:0]  in_handle_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [HANDLE_W-1:0]  cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [STATUS_W-1:0]  out_status_o,
  output logic [SLOT_W-1:0]    out_slot_o,
  output logic [HANDLE_W-1:0]  out_handle_o,
  output logic                 out_in_use_o
);

  localparam int unsigned SW = $clog2(TABLE_SIZE);

  // latched command beat
  logic [CMD_W-1:0]    cmd_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [HANDLE_W-1:0] handle_q;

  logic [HANDLE_W-1:0]   invalid_q;
  logic [TABLE_SIZE-1:0] busy_q;
  logic [NUM_STD-1:0]    wr_q;     // standard slot written since reset

  logic [HANDLE_W-1:0] mem [TABLE_SIZE];
  logic [HANDLE_W-1:0] rdata_q;

  logic          free_found_d, free_found_q;
  logic [SW-1:0] free_idx_d, free_idx_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic                out_in_use_q;

  logic                in_range;
  logic [SW-1:0]       slot_idx;
  logic [HANDLE_W-1:0] stored;
  logic                cfg_std;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_in_use;
  logic                res_set, res_clr;
  logic [SW-1:0]       res_idx;

  logic                mem_we;
  logic [SW-1:0]       mem_waddr;
  logic [HANDLE_W-1:0] mem_wdata;

  assign in_range = ({1'b0, slot_q} < (SLOT_W + 1)'(TABLE_SIZE));
  assign slot_idx = slot_q[SW-1:0];
  assign cfg_std  = cmd_i.cfg_we && (cfg_idx_i != REG_INVALID);

  // unwritten standard slot reads as its reset handle (its index)
  assign stored = ((slot_idx < SW'(NUM_STD)) && !wr_q[slot_idx[STD_W-1:0]]) ?
                  HANDLE_W'(slot_idx) : rdata_q;

  always_comb begin
    free_found_d = 1'b0;
    free_idx_d   = '0;
    for (int i = int'(TABLE_SIZE) - 1; i >= int'(FIRST_ALLOC_SLOT); i--) begin
      if (!busy_q[i]) begin
        free_found_d = 1'b1;
        free_idx_d   = SW'(i);
      end
    end
  end

  always_comb begin
    res_status = STS_OK;
    res_slot   = '0;
    res_handle = '0;
    res_in_use = 1'b0;
    res_set    = 1'b0;
    res_clr    = 1'b0;
    res_idx    = slot_idx;
    case (cmd_q)
      CMD_ALLOC: begin
        if (free_found_q) begin
          res_set  = 1'b1;
          res_idx  = free_idx_q;
          res_slot = SLOT_W'(free_idx_q);
        end else begin
          res_status = STS_FULL;
        end
      end
      CMD_PLACE: begin
        if (in_range) res_set = 1'b1;
        else          res_status = STS_RANGE;
      end
      CMD_LOOKUP: begin
        res_handle = invalid_q;
        if (!in_range) begin
          res_status = STS_RANGE;
        end else if (busy_q[slot_idx]) begin
          res_handle = stored;
          res_in_use = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (in_range) res_clr = 1'b1;
        else          res_status = STS_RANGE;
      end
      CMD_CHECK: begin
        if (in_range) res_in_use = busy_q[slot_idx];
        else          res_status = STS_RANGE;
      end
      default: ;
    endcase
  end

  // released handles need no clear: a slot is only read while in use
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = res_idx;
    mem_wdata = handle_q;
    if (cfg_std) begin
      mem_we    = 1'b1;
      mem_waddr = SW'(cfg_idx_i);
      mem_wdata = cfg_data_i;
    end else if (cmd_i.exec && res_set) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.accept) rdata_q <= mem[in_slot_i[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q    <= in_cmd_i;
      slot_q   <= in_slot_i;
      handle_q <= in_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_q    <= INVALID_RESET;
      busy_q       <= TABLE_SIZE'({NUM_STD{1'b1}});
      wr_q         <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
    end else begin
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      if (cmd_i.cfg_we && (cfg_idx_i == REG_INVALID)) invalid_q <= cfg_data_i;
      if (cfg_std) begin
        busy_q[SW'(cfg_idx_i)]   <= 1'b1;
        wr_q[cfg_idx_i[STD_W-1:0]] <= 1'b1;
      end else if (cmd_i.exec) begin
        if (res_set) begin
          busy_q[res_idx] <= 1'b1;
          if (res_idx < SW'(NUM_STD)) wr_q[res_idx[STD_W-1:0]] <= 1'b1;
        end
        if (res_clr) busy_q[res_idx] <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_handle_q <= res_handle;
      out_in_use_q <= res_in_use;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_handle_o = out_handle_q;
  assign out_in_use_o = out_in_use_q;

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> !cmd_i.accept)
    else $error("accept in consecutive cycles");

  a_exec_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites pending beat");

  a_alloc_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (cmd_q == CMD_ALLOC) && free_found_q) |=> busy_q[$past(free_idx_q)])
    else $error("allocated slot not in use");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (cmd_q == CMD_RELEASE) && in_range) |=> !busy_q[$past(slot_idx)])
    else $error("released slot still in use");

endmodule
`default_nettype wire

>>> test/tb_handle_slot_table.sv
// Self-checking testbench for handle_slot_table: directed and random command beats,
// register rewrites between phases, a scoreboard class that predicts every result.
// Depends on hst_pkg, the channel interfaces in hst_if and the handle_slot_table RTL.
`default_nettype none
module tb_handle_slot_table;
  import hst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned RAND_ROUNDS = 5;
  localparam int unsigned ROUND_ITEMS = 72;
  localparam int unsigned SLOT_MAX    = (1 << SLOT_W) - 1;
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI  = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic                in_use;
  } table_result_t;

  class slot_table_scoreboard;
    logic [HANDLE_W-1:0] handles [HST_TABLE_SIZE];
    bit                  busy [HST_TABLE_SIZE];
    logic [HANDLE_W-1:0] invalid_val;
    table_result_t       pending_q [$];
    int unsigned         fails;

    function new();
      foreach (handles[i]) begin
        handles[i] = '0;
        busy[i]    = 1'b0;
      end
      for (int i = 0; i < NUM_STD; i++) begin
        handles[i] = HANDLE_W'(i);
        busy[i]    = 1'b1;
      end
      invalid_val = INVALID_RESET;
      fails       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HANDLE_W-1:0] data);
      case (idx)
        REG_STDIN, REG_STDOUT, REG_STDERR: begin
          handles[idx] = data;
          busy[idx]    = 1'b1;
        end
        REG_INVALID: invalid_val = data;
        default: ;
      endcase
    endfunction

    function void note_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                           logic [HANDLE_W-1:0] handle);
      table_result_t want;
      bit            in_range;
      int            free_slot;
      want      = '0;
      in_range  = int'(slot) < HST_TABLE_SIZE;
      free_slot = -1;
      case (cmd)
        CMD_ALLOC: begin
          for (int i = HST_TABLE_SIZE - 1; i >= int'(HST_FIRST_ALLOC_SLOT); i--)
            if (!busy[i]) free_slot = i;
          if (free_slot < 0) begin
            want.status = STS_FULL;
          end else begin
            handles[free_slot] = handle;
            busy[free_slot]    = 1'b1;
            want.slot_out      = SLOT_W'(free_slot);
          end
        end
        CMD_PLACE: begin
          if (in_range) begin
            handles[slot] = handle;
            busy[slot]    = 1'b1;
          end else begin
            want.status = STS_RANGE;
          end
        end
        CMD_LOOKUP: begin
          want.handle_out = invalid_val;
          if (!in_range) begin
            want.status = STS_RANGE;
          end else if (busy[slot]) begin
            want.handle_out = handles[slot];
            want.in_use     = 1'b1;
          end
        end
        CMD_RELEASE: begin
          if (in_range) begin
            handles[slot] = '0;
            busy[slot]    = 1'b0;
          end else begin
            want.status = STS_RANGE;
          end
        end
        CMD_CHECK: begin
          if (in_range) want.in_use = busy[slot];
          else want.status = STS_RANGE;
        end
        default: ;
      endcase
      pending_q.push_back(want);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_q.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("unexpected result beat: status %0d slot %0d handle %h in_use %0b",
                   got.status, got.slot_out, got.handle_out, got.in_use);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status || got.slot_out !== want.slot_out ||
            got.handle_out !== want.handle_out || got.in_use !== want.in_use) begin
          fails++;
          if (fails <= REPORT_MAX) begin
            $display("result mismatch: expected status %0d slot %0d handle %h in_use %0b",
                     want.status, want.slot_out, want.handle_out, want.in_use);
            $display("                 actual   status %0d slot %0d handle %h in_use %0b",
                     got.status, got.slot_out, got.handle_out, got.in_use);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          no_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count;
  slot_table_scoreboard sb;

  hst_in_if  in_if ();
  hst_out_if out_if ();
  hst_cfg_if cfg_if ();

  handle_slot_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result({out_if.status, out_if.slot_out, out_if.handle_out,
                         out_if.in_use_out});
      if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 4);
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [HANDLE_W-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                          input logic [HANDLE_W-1:0] handle);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.cmd    <= cmd;
    in_if.slot   <= slot;
    in_if.handle <= handle;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_cmd(cmd, slot, handle);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HANDLE_W-1:0] data,
                           input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    if (last) cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_table_idle();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned alloc_pct [RAND_ROUNDS];
    int unsigned release_pct [RAND_ROUNDS];
    int unsigned pick;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    alloc_pct   = '{30, 10, 55, 30, 55};
    release_pct = '{15, 45, 8, 15, 8};
    sb = new();
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.cmd    <= CMD_ALLOC;
    in_if.slot   <= '0;
    in_if.handle <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.idx   <= REG_STDIN;
    cfg_if.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset contents, free slot lookup, range errors, reuse of a released slot
    send_cmd(CMD_LOOKUP, 8'd0, '0);
    send_cmd(CMD_LOOKUP, 8'd2, '0);
    send_cmd(CMD_CHECK, 8'd1, '0);
    send_cmd(CMD_CHECK, 8'd3, '0);
    send_cmd(CMD_LOOKUP, 8'd3, '0);
    send_cmd(CMD_ALLOC, 8'd0, '1);
    send_cmd(CMD_ALLOC, SLOT_W'(SLOT_MAX), '0);
    send_cmd(CMD_LOOKUP, 8'd3, '0);
    send_cmd(CMD_PLACE, SLOT_W'(HST_TABLE_SIZE - 1), 64'h0123_4567_89ab_cdef);
    send_cmd(CMD_PLACE, SLOT_W'(HST_TABLE_SIZE), '1);
    send_cmd(CMD_PLACE, SLOT_W'(SLOT_MAX), '1);
    send_cmd(CMD_LOOKUP, SLOT_W'(HST_TABLE_SIZE - 1), '0);
    send_cmd(CMD_LOOKUP, SLOT_W'(HST_TABLE_SIZE), '0);
    send_cmd(CMD_LOOKUP, SLOT_W'(SLOT_MAX), '0);
    send_cmd(CMD_RELEASE, SLOT_W'(SLOT_MAX), '0);
    send_cmd(CMD_CHECK, 8'd128, '0);
    send_cmd(CMD_RELEASE, 8'd3, '0);
    send_cmd(CMD_ALLOC, 8'd0, 64'hfedc_ba98_7654_3210);
    send_cmd(CMD_RELEASE, 8'd0, '0);
    send_cmd(CMD_LOOKUP, 8'd0, '0);
    send_cmd(CMD_PLACE, 8'd0, rand_value());
    send_cmd(CMD_UNDEF_LO, SLOT_W'(SLOT_MAX), '1);
    send_cmd(CMD_UNDEF_MID, 8'd0, '1);
    send_cmd(CMD_UNDEF_HI, 8'd3, '1);
    send_cmd(CMD_CHECK, SLOT_W'(HST_TABLE_SIZE - 1), '0);
    wait_table_idle();

    write_reg(REG_STDIN, '1, 1'b0);
    write_reg(REG_STDOUT, '0, 1'b0);
    write_reg(REG_STDERR, {$urandom, $urandom}, 1'b0);
    write_reg(REG_INVALID, '0, 1'b1);
    wait_table_idle();
    send_cmd(CMD_LOOKUP, 8'd0, '0);
    send_cmd(CMD_LOOKUP, 8'd1, '0);
    send_cmd(CMD_LOOKUP, 8'd2, '0);
    send_cmd(CMD_LOOKUP, 8'd5, '0);

    // run allocation until the table reports full
    for (int k = 0; k < HST_TABLE_SIZE; k++) send_cmd(CMD_ALLOC, SLOT_W'($urandom), rand_value());
    wait_table_idle();

    for (int r = 0; r < RAND_ROUNDS; r++) begin
      write_reg(REG_STDIN, rand_value(), 1'b0);
      write_reg(REG_STDOUT, rand_value(), 1'b0);
      write_reg(REG_STDERR, rand_value(), 1'b0);
      write_reg(REG_INVALID, (r == 0) ? '0 : (r == 2) ? '1 : rand_value(), 1'b1);
      wait_table_idle();
      if (r == RAND_ROUNDS - 1) no_idle = 1'b1;
      for (int k = 0; k < ROUND_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          cmd = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        end else if (pick < 3 + alloc_pct[r]) begin
          cmd = CMD_ALLOC;
        end else if (pick < 3 + alloc_pct[r] + release_pct[r]) begin
          cmd = CMD_RELEASE;
        end else begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_PLACE;
            1: cmd = CMD_LOOKUP;
            default: cmd = CMD_CHECK;
          endcase
        end
        if ($urandom_range(0, 9) == 0)
          slot = SLOT_W'($urandom_range(HST_TABLE_SIZE, SLOT_MAX));
        else
          slot = SLOT_W'($urandom_range(0, HST_TABLE_SIZE - 1));
        send_cmd(cmd, slot, rand_value());
      end
      wait_table_idle();
    end

    if (sb.fails == 0 && sb.pending_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
